### hw/rtl/tfc_pkg.sv
// Shared constants and types of the cycle counter frequency calibrator.
package tfc_pkg;

    // Field and register widths.
    localparam int FREQ_W = 32;
    localparam int WDIV_W = 16;
    localparam int REF_W  = 32;
    localparam int CYC_W  = 64;
    localparam int PROD_W = CYC_W + FREQ_W;
    localparam int WPROD_W = REF_W + 1 + WDIV_W;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    // Reset values of the configuration registers.
    localparam logic [FREQ_W-1:0] FREQ_RST = 32'd3579545;
    localparam logic [WDIV_W-1:0] WDIV_RST = 16'd100;

    // Largest gap that is still taken as a 24-bit wrap, and the 24-bit modulus.
    localparam logic [REF_W-1:0] WRAP24_MAX = 32'h00FF_FFFF;
    localparam logic [REF_W-1:0] WRAP24_MOD = 32'h0100_0000;

    // Serial unit step counts and counter widths.
    localparam int MUL_STEPS = FREQ_W;
    localparam int DIV_STEPS = CYC_W;
    localparam int MCNT_W = $clog2(MUL_STEPS);
    localparam int DCNT_W = $clog2(DIV_STEPS);

    // Register index, taken from paddr bit 2.
    localparam logic REG_FREQ = 1'b0;
    localparam logic REG_WDIV = 1'b1;

    // Item kinds.
    localparam logic KIND_START  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // Status of a serial arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

### hw/rtl/tfc_mul.sv
// Bit-serial 64 x 32 multiplier, one multiplier bit per cycle.
module tfc_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tfc_pkg::CYC_W-1:0]   i_a,
    input  logic [tfc_pkg::FREQ_W-1:0]  i_b,
    output logic [tfc_pkg::PROD_W-1:0]  o_prod,
    output tfc_pkg::t_unit_stat         o_stat
);
    import tfc_pkg::*;

    logic [PROD_W-1:0] r_prod;
    logic [CYC_W-1:0]  r_a;
    logic [MCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [CYC_W:0]    w_sum;

    // Add the multiplicand to the upper part when the current multiplier bit is set.
    assign w_sum = {1'b0, r_prod[PROD_W-1:FREQ_W]} + (r_prod[0] ? {1'b0, r_a} : '0);

    // Control: step counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MCNT_W'(MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the multiplier shifts out of the low end as product bits come in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= {{CYC_W{1'b0}}, i_b};
            r_a    <= i_a;
        end else if (r_busy) begin
            r_prod <= {w_sum, r_prod[FREQ_W-1:1]};
        end
    end

    assign o_prod = r_prod;
    assign o_stat = '{busy: r_busy, done: r_done};

endmodule

### hw/rtl/tfc_div.sv
// Bit-serial restoring divider, 96 by 32 bits, 64-bit quotient saturated to all ones.
module tfc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tfc_pkg::PROD_W-1:0]  i_num,
    input  logic [tfc_pkg::REF_W-1:0]   i_den,
    output logic [tfc_pkg::CYC_W-1:0]   o_quot,
    output tfc_pkg::t_unit_stat         o_stat
);
    import tfc_pkg::*;

    logic [REF_W-1:0]  r_rem;
    logic [CYC_W-1:0]  r_q;
    logic [REF_W-1:0]  r_den;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic              w_sat;
    logic [REF_W:0]    w_trial;
    logic [REF_W:0]    w_diff;
    logic              w_ge;

    // The quotient only fits when the top word is below the divisor; a zero divisor never fits.
    assign w_sat = (i_num[PROD_W-1:CYC_W] >= i_den);

    // One restoring step: bring down the next numerator bit and try a subtract.
    assign w_trial = {r_rem, r_q[CYC_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    // Control: step counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt  <= '0;
                r_busy <= !w_sat;
                r_done <= w_sat;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: numerator bits leave the top of r_q while quotient bits enter at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= i_num[PROD_W-1:CYC_W];
            r_q   <= w_sat ? '1 : i_num[CYC_W-1:0];
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[REF_W-1:0] : w_trial[REF_W-1:0];
            r_q   <= {r_q[CYC_W-2:0], w_ge};
        end
    end

    assign o_quot = r_q;
    assign o_stat = '{busy: r_busy, done: r_done};

endmodule

### hw/rtl/pm_timer_tsc_frequency_calibrator.sv
// Top level of the cycle counter frequency calibrator: control, registers and serial units.
//
// Usage. Input beats (i_kind, i_ref_count, i_cycle_count) arrive on a valid/ready
// channel; each one yields exactly one output beat (o_done_res, o_freq_hz,
// o_ref_delta) on a second valid/ready channel. A start beat captures the
// reference and cycle readings and clears any earlier result. A sample beat
// reports the wrap-corrected reference delta; the first sample whose delta
// reaches ref_freq_hz / window_divisor computes cycle_delta * ref_freq_hz / delta
// and the block keeps reporting that frequency until the next start.
// A start beat goes from the accepting edge through S_EVAL to S_OUT; a sample that does not
// compute goes through S_EVAL, S_WIN and S_CMP to S_OUT; the sample that completes the
// measurement also runs S_MUL and S_DIV for the bit-serial multiplier (32 steps) and
// divider (64 steps, none when the quotient saturates). One beat is in flight at a time; the
// next input beat is taken once the result sits in the output register, even
// if the receiver has not taken it yet. When the receiver stalls with a result
// still waiting, the block holds the new result internally and stops taking input.
// Reset restores ref_freq_hz = 3579545, window_divisor = 100 and clears all measurement
// state. Registers are written over the APB port at byte offsets 0 (ref_freq_hz) and 4
// (window_divisor); the user writes them only while the block is idle, unchecked by it.
module pm_timer_tsc_frequency_calibrator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Input channel.
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_kind,
    input  logic [tfc_pkg::REF_W-1:0]   i_ref_count,
    input  logic [tfc_pkg::CYC_W-1:0]   i_cycle_count,
    // Output channel.
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_done_res,
    output logic [tfc_pkg::CYC_W-1:0]   o_freq_hz,
    output logic [tfc_pkg::REF_W-1:0]   o_ref_delta,
    // Configuration port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tfc_pkg::ADDR_W-1:0]  paddr,
    input  logic [tfc_pkg::DATA_W-1:0]  pwdata,
    output logic [tfc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import tfc_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EVAL = 7'b0000010,
        S_WIN  = 7'b0000100,
        S_CMP  = 7'b0001000,
        S_MUL  = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state             r_state;
    logic [FREQ_W-1:0]  r_freq_cfg;
    logic [WDIV_W-1:0]  r_wdiv_cfg;

    logic               r_kind;
    logic [REF_W-1:0]   r_ref;
    logic [CYC_W-1:0]   r_cyc;
    logic [REF_W-1:0]   r_start_ref;
    logic [CYC_W-1:0]   r_start_cyc;
    logic               r_finished;
    logic [CYC_W-1:0]   r_latched;
    logic [REF_W-1:0]   r_delta;
    logic [WPROD_W-1:0] r_wprod;

    logic               r_out_valid;
    logic               r_out_done;
    logic [CYC_W-1:0]   r_out_freq;
    logic [REF_W-1:0]   r_out_delta;

    logic               w_in_fire;
    logic               w_cfg_wr;
    logic [REF_W-1:0]   w_diff;
    logic [REF_W-1:0]   w_gap;
    logic [REF_W-1:0]   w_delta;
    logic [WDIV_W-1:0]  w_wdiv_eff;
    logic               w_compute;
    logic               w_mul_start;
    logic               w_div_start;
    logic               w_out_load;
    logic [PROD_W-1:0]  w_prod;
    logic [CYC_W-1:0]   w_quot;
    t_unit_stat         w_mul_stat;
    t_unit_stat         w_div_stat;

    // Configuration port: zero-wait writes and reads.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    always_comb begin
        unique case (paddr[2])
            REG_FREQ: prdata = r_freq_cfg;
            REG_WDIV: prdata = {{(DATA_W-WDIV_W){1'b0}}, r_wdiv_cfg};
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq_cfg <= FREQ_RST;
            r_wdiv_cfg <= WDIV_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_FREQ: r_freq_cfg <= pwdata[FREQ_W-1:0];
                REG_WDIV: r_wdiv_cfg <= pwdata[WDIV_W-1:0];
                default:  r_freq_cfg <= r_freq_cfg;
            endcase
        end
    end

    // Wrap-corrected reference delta: a short backward gap is a 24-bit wrap.
    assign w_diff  = r_ref - r_start_ref;
    assign w_gap   = r_start_ref - r_ref;
    assign w_delta = ((r_ref < r_start_ref) && (w_gap <= WRAP24_MAX)) ?
                     (w_diff + WRAP24_MOD) : w_diff;

    // Window test without a divider: delta >= floor(F / d) exactly when F < (delta + 1) * d.
    assign w_wdiv_eff = (r_wdiv_cfg == '0) ? WDIV_W'(1) : r_wdiv_cfg;
    assign w_compute  = !r_finished && ({{(WPROD_W-FREQ_W){1'b0}}, r_freq_cfg} < r_wprod);

    // Handshakes and unit starts.
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_mul_start = (r_state == S_CMP) && w_compute;
    assign w_div_start = (r_state == S_MUL) && w_mul_stat.done;
    assign w_out_load  = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (w_in_fire) r_state <= S_EVAL;
                S_EVAL: r_state <= (r_kind == KIND_START) ? S_OUT : S_WIN;
                S_WIN:  r_state <= S_CMP;
                S_CMP:  r_state <= w_compute ? S_MUL : S_OUT;
                S_MUL:  if (w_mul_stat.done) r_state <= S_DIV;
                S_DIV:  if (w_div_stat.done) r_state <= S_OUT;
                S_OUT:  if (w_out_load) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Input capture and window product.
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_kind <= i_kind;
            r_ref  <= i_ref_count;
            r_cyc  <= i_cycle_count;
        end
        if (r_state == S_EVAL) begin
            r_delta <= (r_kind == KIND_START) ? '0 : w_delta;
        end
        if (r_state == S_WIN) begin
            r_wprod <= ({{(WDIV_W+1){1'b0}}, r_delta} + WPROD_W'(1)) *
                       {{(WPROD_W-WDIV_W){1'b0}}, w_wdiv_eff};
        end
    end

    // Measurement state: start values, finished flag and latched frequency.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_ref <= '0;
            r_start_cyc <= '0;
            r_finished  <= 1'b0;
            r_latched   <= '0;
        end else if ((r_state == S_EVAL) && (r_kind == KIND_START)) begin
            r_start_ref <= r_ref;
            r_start_cyc <= r_cyc;
            r_finished  <= 1'b0;
            r_latched   <= '0;
        end else if ((r_state == S_DIV) && w_div_stat.done) begin
            r_finished <= 1'b1;
            r_latched  <= w_quot;
        end
    end

    // Serial multiply of cycle delta by the reference frequency, then divide by delta.
    tfc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (r_cyc - r_start_cyc),
        .i_b     (r_freq_cfg),
        .o_prod  (w_prod),
        .o_stat  (w_mul_stat)
    );

    tfc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_prod),
        .i_den   (r_delta),
        .o_quot  (w_quot),
        .o_stat  (w_div_stat)
    );

    // Output register: holds one beat for the receiver.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_done  <= r_finished;
            r_out_freq  <= r_latched;
            r_out_delta <= r_delta;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_done_res  = r_out_done;
    assign o_freq_hz   = r_out_freq;
    assign o_ref_delta = r_out_delta;

`ifndef SYNTHESIS
    // The multiplier and divider never run at the same time.
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mul_stat.busy && w_div_stat.busy))
        else $error("multiplier and divider busy together");

    // A result is only latched when the divider finishes.
    a_finish_from_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_finished) |-> $past(r_state == S_DIV))
        else $error("finished flag set outside the divide step");

    // Without a finished measurement the latched frequency stays zero.
    a_latched_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_finished |-> (r_latched == '0))
        else $error("latched frequency nonzero before finishing");

    // A start beat clears the result and reports a zero delta.
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EVAL) && (r_kind == KIND_START)) |=> (!r_finished && (r_delta == '0)))
        else $error("start beat did not clear the measurement");
`endif

endmodule
